// ----- hdl/uenc_pkg.sv -----
// Types, constants and helper functions shared by the URL percent encoder.
package uenc_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } uenc_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } uenc_rsp_type;

   localparam int unsigned SLOTS = 7;

   // One command per input beat that produces output. Slot 0 is a percent sign, slots 1 and 2
   // are the digits 2 and 5, slot 3 is the held digit, slot 4 is the new byte or a percent
   // sign, and slots 5 and 6 are the hex digits of the new byte.
   typedef struct packed {
      logic [SLOTS-1:0] mask;
      logic [7:0]       digit;
      logic [7:0]       tail;
      logic             last;
   } uenc_cmd_type;

   localparam logic [SLOTS-1:0] MASK_HEAD25 = 7'b0000111;
   localparam logic [SLOTS-1:0] MASK_LEAD   = 7'b0000001;
   localparam logic [SLOTS-1:0] MASK_DIGIT  = 7'b0001000;
   localparam logic [SLOTS-1:0] MASK_RAW    = 7'b0010000;
   localparam logic [SLOTS-1:0] MASK_ESC    = 7'b1110000;

   localparam logic [2:0] MODE_PATH = 3'd0;
   localparam logic [2:0] MODE_FIX  = 3'd2;
   localparam logic [2:0] MODE_CTRL = 3'd4;

   localparam logic [1:0] HELD_NONE  = 2'd0;
   localparam logic [1:0] HELD_PCT   = 2'd1;
   localparam logic [1:0] HELD_DIGIT = 2'd2;

   localparam logic [7:0] CHAR_PCT = 8'h25;
   localparam logic [7:0] CHAR_TWO = 8'h32;
   localparam logic [7:0] CHAR_FIVE = 8'h35;
   localparam logic [7:0] CHAR_DEL = 8'h7f;

   localparam logic [3:0] CLASS_TABLE [0:95] = '{
      4'h0, 4'h0, 4'h0, 4'h0, 4'h7, 4'h0, 4'h4, 4'h0,
      4'h7, 4'h7, 4'h7, 4'h0, 4'hf, 4'hf, 4'hf, 4'hf,
      4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf,
      4'hf, 4'hf, 4'h6, 4'h0, 4'h0, 4'h4, 4'h0, 4'h4,
      4'h0, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf,
      4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf,
      4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf,
      4'hf, 4'hf, 4'hf, 4'h4, 4'h0, 4'h4, 4'h0, 4'hf,
      4'h0, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf,
      4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf,
      4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf,
      4'hf, 4'hf, 4'hf, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0
   };

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic passes_through(input logic [2:0] mode, input logic [7:0] c);
      logic [6:0] idx;
      logic [3:0] cls;
      logic       res;
      idx = 7'd0;
      cls = 4'd0;
      if (mode == MODE_CTRL) begin
         res = !(c < 8'd32 || c == CHAR_DEL || c == CHAR_PCT);
      end else if (c[7] || c[6:5] == 2'b00) begin
         res = 1'b0;
      end else begin
         idx = c[6:0] - 7'd32;
         cls = CLASS_TABLE[idx];
         res = cls[mode[1:0]];
      end
      return res;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
   endfunction

endpackage

// ----- hdl/uenc_front.sv -----
// Front end: mode register, hold state and classification of each input beat into a command.
module uenc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  uenc_pkg::uenc_req_type req_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_data,
   input  logic                  q_full,
   output logic                  q_push,
   output uenc_pkg::uenc_cmd_type q_data
);
   import uenc_pkg::*;

   logic [2:0] mode_ff, mode_in;
   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_digit_ff, held_digit_in;
   logic [2:0] eff_mode;
   logic       accept;
   logic       c_hex;
   logic       fresh_hold;
   logic [SLOTS-1:0] coded_mask;
   logic [SLOTS-1:0] fresh_mask;
   logic [SLOTS-1:0] mask;
   logic [7:0] c;
   logic       last;

   assign c         = req_data.in_byte;
   assign last      = req_data.in_last;
   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign eff_mode  = (mode_ff > MODE_CTRL) ? MODE_PATH : mode_ff;
   assign c_hex     = is_hex(c);

   assign coded_mask = passes_through(eff_mode, c) ? MASK_RAW : MASK_ESC;
   assign fresh_hold = (eff_mode == MODE_FIX) && (c == CHAR_PCT) && !last;
   assign fresh_mask = fresh_hold ? '0 : coded_mask;

   always_comb begin
      mask          = '0;
      held_count_in = HELD_NONE;
      held_digit_in = held_digit_ff;
      unique case (held_count_ff)
         HELD_PCT: begin
            if (c_hex && !last) begin
               held_count_in = HELD_DIGIT;
               held_digit_in = c;
            end else begin
               mask          = MASK_HEAD25 | fresh_mask;
               held_count_in = fresh_hold ? HELD_PCT : HELD_NONE;
            end
         end
         HELD_DIGIT: begin
            if (c_hex) begin
               mask = MASK_LEAD | MASK_DIGIT | coded_mask;
            end else begin
               mask          = MASK_HEAD25 | MASK_DIGIT | fresh_mask;
               held_count_in = fresh_hold ? HELD_PCT : HELD_NONE;
            end
         end
         default: begin
            mask          = fresh_mask;
            held_count_in = fresh_hold ? HELD_PCT : HELD_NONE;
         end
      endcase
   end

   assign q_push       = accept && (mask != '0);
   assign q_data.mask  = mask;
   assign q_data.digit = held_digit_ff;
   assign q_data.tail  = c;
   assign q_data.last  = last;

   assign mode_in = (csr_valid && csr_ready) ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_PATH;
         held_count_ff <= HELD_NONE;
         held_digit_ff <= 8'd0;
      end else begin
         mode_ff <= mode_in;
         if (accept) begin
            held_count_ff <= held_count_in;
            held_digit_ff <= held_digit_in;
         end
      end
   end

endmodule

// ----- hdl/uenc_queue.sv -----
// Short register queue of commands between the front end and the back end.
module uenc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  uenc_pkg::uenc_cmd_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   valid,
   output uenc_pkg::uenc_cmd_type head
);
   import uenc_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   uenc_cmd_type   entry_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign valid   = (count_ff != '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   assign wr_ptr_in = do_push ? ((wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? ((rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign count_in  = count_ff + CW'(do_push) - CW'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/uenc_back.sv -----
// Back end: walks the slots of the head command and sends one byte per beat to the output register.
module uenc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  uenc_pkg::uenc_cmd_type head,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output uenc_pkg::uenc_rsp_type rsp_data
);
   import uenc_pkg::*;

   logic [SLOTS-1:0] done_ff, done_in;
   logic [SLOTS-1:0] remaining;
   logic [SLOTS-1:0] pick;
   logic [SLOTS-1:0] rest;
   logic             rsp_valid_ff, rsp_valid_in;
   uenc_rsp_type     rsp_ff, rsp_in;
   logic             out_free;
   logic             fire;
   logic [7:0]       pick_byte;

   assign remaining = head.mask & ~done_ff;
   assign pick      = remaining & (~remaining + 1'b1);
   assign rest      = remaining & ~pick;
   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign fire      = q_valid && out_free;
   assign q_pop     = fire && (rest == '0);

   always_comb begin
      priority if (pick[0]) begin
         pick_byte = CHAR_PCT;
      end else if (pick[1]) begin
         pick_byte = CHAR_TWO;
      end else if (pick[2]) begin
         pick_byte = CHAR_FIVE;
      end else if (pick[3]) begin
         pick_byte = head.digit;
      end else if (pick[4]) begin
         pick_byte = head.mask[5] ? CHAR_PCT : head.tail;
      end else if (pick[5]) begin
         pick_byte = hex_char(head.tail[7:4]);
      end else begin
         pick_byte = hex_char(head.tail[3:0]);
      end
   end

   always_comb begin
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (fire) begin
         done_in         = (rest == '0) ? '0 : (done_ff | pick);
         rsp_valid_in    = 1'b1;
         rsp_in.out_byte = pick_byte;
         rsp_in.out_last = head.last && (rest == '0);
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_done_within_mask: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> ((done_ff & ~head.mask) == '0))
      else $error("sent slots are not part of the head command");

   a_done_clear_when_idle: assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> (done_ff == '0))
      else $error("slot progress left over with no command waiting");

   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> !rsp_empty)
      else $error("a sent byte did not reach the output register");

endmodule

// ----- hdl/url_percent_encoder_unit.sv -----
// Top level of the streaming URL percent encoder.
//
// Input: one string byte per beat on req_data (in_byte, in_last), taken when req_push is high
// and req_full is low. Output: one encoded byte per beat on rsp_data (out_byte, out_last),
// valid while rsp_empty is low and taken when rsp_pop is high. out_last marks the final byte
// of a string. The escape mode is written through csr_valid/csr_ready/csr_data; the user must
// write it only while the block is idle, as the block itself does not enforce this. csr_ready
// is always high. A beat that produces output is registered in the command queue and then in
// the output register before its first byte is on rsp_data. A byte that passes through gives
// one output byte and an escaped byte three; a beat may carry up to seven output bytes. The
// back end sends one byte per cycle while the output register is free, so the sustained rate is
// one input beat per cycle for transparent bytes and less for escaped bytes. A '%' held in fix
// mode produces nothing until the following bytes settle it.
// The command queue between the front and back end holds QUEUE_DEPTH commands; req_full
// rises when it is full, so a stall at the output backs up into the input after that.
// Synchronous reset sets the mode to path, drops any held bytes and empties the block.
module url_percent_encoder_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  uenc_pkg::uenc_req_type req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output uenc_pkg::uenc_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_data
);
   import uenc_pkg::*;

   logic         q_full;
   logic         q_push;
   logic         q_pop;
   logic         q_valid;
   uenc_cmd_type q_in;
   uenc_cmd_type q_head;

   uenc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   uenc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   uenc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .head      (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
